// ===== sv/rts_pkg.sv =====
// Package for the reliable transport sender: transfer item types, config
// bundle, state encoding, function code, header flag, register index and
// reset value constants and a result builder. No dependencies.
package rts_pkg;

  localparam logic [4:0] FLAG_NONE = 5'd0;
  localparam logic [4:0] FLAG_DAT  = 5'd1;
  localparam logic [4:0] FLAG_ACK  = 5'd2;
  localparam logic [4:0] FLAG_SYN  = 5'd4;
  localparam logic [4:0] FLAG_FIN  = 5'd8;

  localparam int unsigned BIT_ACK = 1;
  localparam int unsigned BIT_SYN = 2;
  localparam int unsigned BIT_FIN = 3;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_RX    = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [1:0] REG_FILE_LENGTH        = 2'd0;
  localparam logic [1:0] REG_INITIAL_SEQUENCE   = 2'd1;
  localparam logic [1:0] REG_RETRANSMIT_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_ADVERTISED_WINDOW  = 2'd3;

  localparam logic [15:0] RST_INITIAL_SEQUENCE   = 16'd100;
  localparam logic [15:0] RST_RETRANSMIT_TIMEOUT = 16'd100;
  localparam logic [15:0] RST_ADVERTISED_WINDOW  = 16'd4096;

  typedef enum logic [2:0] {
    ST_WAITING = 3'd0,
    ST_SYN     = 3'd1,
    ST_SYN_RET = 3'd2,
    ST_SENDING = 3'd3,
    ST_EOF     = 3'd4,
    ST_FIN     = 3'd5,
    ST_FIN_ACK = 3'd6,
    ST_DONE    = 3'd7
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  rx_type;
    logic [15:0] rx_seq;
    logic [15:0] rx_ack;
    logic [15:0] rx_window;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  tx_type;
    logic [15:0] tx_seq;
    logic [15:0] tx_ack;
    logic [15:0] tx_payload_len;
    logic [15:0] tx_window;
    logic [31:0] tx_file_offset;
    logic        finished;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] file_length;
    logic [15:0] initial_sequence;
    logic [15:0] retransmit_timeout;
    logic [15:0] advertised_window;
  } cfg_t;

  function automatic out_item_t make_res(input logic [4:0]  t,
                                         input logic [15:0] s,
                                         input logic [15:0] a,
                                         input logic [15:0] l,
                                         input logic [31:0] off,
                                         input logic        fin,
                                         input logic [15:0] adv);
    out_item_t r;
    r.tx_type        = t;
    r.tx_seq         = s;
    r.tx_ack         = a;
    r.tx_payload_len = l;
    r.tx_window      = (t != FLAG_NONE) ? adv : 16'd0;
    r.tx_file_offset = off;
    r.finished       = fin;
    r.last           = 1'b0;
    return r;
  endfunction

endpackage

// ===== sv/reliable_transport_sender.sv =====
// Top level of the reliable transport sender: configuration registers,
// input register, connection state machine and result queue.
// Uses rts_pkg, rts_step and rts_result_queue.
//
// An accepted item is held in the input register for the next cycle, in
// which the state machine processes it. Its result headers, up to two, enter
// the result queue at the end of that cycle. The input side takes an item
// only while the queue has room for two results of the item in the input
// register and two of the new one, so a new item can be taken while the
// last one is still in the input register. With the default queue depth of
// four, two back-to-back items are taken from an idle block. After that,
// intake follows the drain of the queue through the output port, which
// moves one header per cycle while out_stall is low, so items that yield
// two headers are taken more slowly than items that yield one.
module reliable_transport_sender #(
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rts_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output rts_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int unsigned CW = $clog2(OUT_DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  rts_pkg::cfg_t      cfg_r;
  rts_pkg::in_item_t  item_r;
  logic               item_v_r;
  rts_pkg::out_item_t res0, res1;
  logic [1:0]         res_n;
  logic [CW-1:0]      q_count;
  logic [SW-1:0]      need;
  logic               in_accept, out_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.file_length        <= '0;
      cfg_r.initial_sequence   <= rts_pkg::RST_INITIAL_SEQUENCE;
      cfg_r.retransmit_timeout <= rts_pkg::RST_RETRANSMIT_TIMEOUT;
      cfg_r.advertised_window  <= rts_pkg::RST_ADVERTISED_WINDOW;
    end else if (cfg_we) begin
      case (cfg_index)
        rts_pkg::REG_FILE_LENGTH:        cfg_r.file_length        <= cfg_wdata;
        rts_pkg::REG_INITIAL_SEQUENCE:   cfg_r.initial_sequence   <= cfg_wdata[15:0];
        rts_pkg::REG_RETRANSMIT_TIMEOUT: cfg_r.retransmit_timeout <= cfg_wdata[15:0];
        rts_pkg::REG_ADVERTISED_WINDOW:  cfg_r.advertised_window  <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // reserve two queue slots for every item in flight
  assign need      = SW'(q_count) + (item_v_r ? SW'(2) : SW'(0)) + SW'(2);
  assign in_stall  = (need > SW'(OUT_DEPTH));
  assign in_accept = in_valid && !in_stall;
  assign out_pop   = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_item;
    end
  end

  rts_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_v (item_v_r),
    .item   (item_r),
    .cfg    (cfg_r),
    .res0   (res0),
    .res1   (res1),
    .res_n  (res_n)
  );

  rts_result_queue #(
    .DEPTH (OUT_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (res_n),
    .push0     (res0),
    .push1     (res1),
    .pop       (out_pop),
    .head      (out_item),
    .not_empty (out_valid),
    .count     (q_count)
  );

  a_room_for_item: assert property (@(posedge clk) disable iff (!rst_n)
    item_v_r |-> (SW'(q_count) + SW'(2)) <= SW'(OUT_DEPTH))
    else $error("item processed without queue room");

  a_finish_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.finished |-> out_item.last)
    else $error("closing result not marked last");

endmodule

// ===== sv/rts_step.sv =====
// Connection state machine of the sender: holds the protocol state and turns
// one registered input item into up to two result headers. Uses rts_pkg.
module rts_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_v,
  input  rts_pkg::in_item_t  item,
  input  rts_pkg::cfg_t      cfg,
  output rts_pkg::out_item_t res0,
  output rts_pkg::out_item_t res1,
  output logic [1:0]         res_n
);

  rts_pkg::state_t fsm_r, fsm_nxt;
  logic [15:0] exp_ack_r, exp_ack_nxt;
  logic [15:0] next_seq_r, next_seq_nxt;
  logic [15:0] last_acked_r, last_acked_nxt;
  logic [15:0] peer_win_r, peer_win_nxt;
  logic [31:0] rd_off_r, rd_off_nxt;
  logic        ov_r, ov_nxt;
  logic [15:0] os_r, os_nxt;
  logic [15:0] ol_r, ol_nxt;
  logic [31:0] ooff_r, ooff_nxt;
  logic [31:0] otime_r, otime_nxt;
  logic [31:0] now_r, now_nxt;

  rts_pkg::out_item_t r0_v, r1_v, x;
  logic [1:0]  n_v;

  always_comb begin
    logic is_ack, is_syn, is_fin, drop, ack_syn, chunk_req, fin_req, do_resend;
    logic [31:0] left;
    logic [15:0] len;
    fsm_nxt        = fsm_r;
    exp_ack_nxt    = exp_ack_r;
    next_seq_nxt   = next_seq_r;
    last_acked_nxt = last_acked_r;
    peer_win_nxt   = peer_win_r;
    rd_off_nxt     = rd_off_r;
    ov_nxt         = ov_r;
    os_nxt         = os_r;
    ol_nxt         = ol_r;
    ooff_nxt       = ooff_r;
    otime_nxt      = otime_r;
    now_nxt        = now_r;
    r0_v = '0;
    r1_v = '0;
    x    = '0;
    n_v  = 2'd0;
    is_ack    = item.rx_type[rts_pkg::BIT_ACK];
    is_syn    = item.rx_type[rts_pkg::BIT_SYN];
    is_fin    = item.rx_type[rts_pkg::BIT_FIN];
    drop      = 1'b0;
    ack_syn   = 1'b0;
    chunk_req = 1'b0;
    fin_req   = 1'b0;
    do_resend = 1'b0;
    left      = '0;
    len       = '0;

    if (item_v) begin
      case (item.func)
        rts_pkg::FUNC_START: begin
          if (fsm_r == rts_pkg::ST_WAITING) begin
            exp_ack_nxt = cfg.initial_sequence;
            fsm_nxt     = rts_pkg::ST_SYN;
            x = rts_pkg::make_res(rts_pkg::FLAG_SYN, cfg.initial_sequence, 16'd0,
                                  16'd0, 32'd0, 1'b0, cfg.advertised_window);
            r0_v = x;
            n_v  = 2'd1;
          end
        end
        rts_pkg::FUNC_TICK: begin
          now_nxt = now_r + 32'd1;
          if (fsm_r == rts_pkg::ST_SENDING && ov_r &&
              (now_nxt - otime_r) > {16'd0, cfg.retransmit_timeout}) begin
            do_resend = 1'b1;
          end
        end
        rts_pkg::FUNC_RX: begin
          case (fsm_r)
            rts_pkg::ST_SYN: begin
              if (is_ack) begin
                if (item.rx_ack != exp_ack_r) begin
                  drop = 1'b1;
                end else begin
                  peer_win_nxt = item.rx_window;
                  fsm_nxt      = rts_pkg::ST_SYN_RET;
                end
              end
              if (!drop && is_syn && fsm_nxt == rts_pkg::ST_SYN_RET) begin
                ack_syn = 1'b1;
              end
            end
            rts_pkg::ST_SYN_RET: begin
              ack_syn = is_syn;
            end
            rts_pkg::ST_SENDING: begin
              if (is_ack) begin
                if (item.rx_ack == last_acked_r) begin
                  do_resend = 1'b1;
                end else if (ov_r && os_r == item.rx_ack) begin
                  last_acked_nxt = item.rx_ack;
                  ov_nxt         = 1'b0;
                  peer_win_nxt   = item.rx_window;
                  chunk_req      = 1'b1;
                end else if (!ov_r) begin
                  peer_win_nxt = item.rx_window;
                  chunk_req    = 1'b1;
                end
              end
            end
            rts_pkg::ST_EOF: begin
              if (is_ack && ov_r && os_r == item.rx_ack) begin
                ov_nxt       = 1'b0;
                peer_win_nxt = item.rx_window;
                fin_req      = 1'b1;
              end
            end
            rts_pkg::ST_FIN: begin
              if (is_ack) begin
                if (item.rx_ack != exp_ack_r) begin
                  drop = 1'b1;
                end else begin
                  fsm_nxt = rts_pkg::ST_FIN_ACK;
                end
              end
              if (!drop && is_fin) begin
                fsm_nxt = rts_pkg::ST_FIN_ACK;
                r0_v = rts_pkg::make_res(rts_pkg::FLAG_ACK, 16'd0, item.rx_seq, 16'd0,
                                         32'd0, 1'b0, cfg.advertised_window);
                n_v  = 2'd1;
              end
            end
            rts_pkg::ST_FIN_ACK: begin
              if (is_ack) begin
                if (item.rx_ack == exp_ack_r) begin
                  fsm_nxt = rts_pkg::ST_DONE;
                  r0_v = rts_pkg::make_res(rts_pkg::FLAG_NONE, 16'd0, 16'd0, 16'd0,
                                           32'd0, 1'b1, cfg.advertised_window);
                  n_v  = 2'd1;
                end
              end else if (is_fin) begin
                fsm_nxt = rts_pkg::ST_DONE;
                r0_v = rts_pkg::make_res(rts_pkg::FLAG_ACK, 16'd0, item.rx_seq, 16'd0,
                                         32'd0, 1'b1, cfg.advertised_window);
                n_v  = 2'd1;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase

      if (do_resend && ov_r) begin
        otime_nxt = now_nxt;
        r0_v = rts_pkg::make_res(rts_pkg::FLAG_DAT, os_r, 16'd0, ol_r, ooff_r, 1'b0,
                                 cfg.advertised_window);
        n_v  = 2'd1;
      end

      if (ack_syn) begin
        r0_v = rts_pkg::make_res(rts_pkg::FLAG_ACK, item.rx_seq, item.rx_seq, 16'd0,
                                 32'd0, 1'b0, cfg.advertised_window);
        n_v          = 2'd1;
        fsm_nxt      = rts_pkg::ST_SENDING;
        next_seq_nxt = item.rx_seq + 16'd1;
        chunk_req    = 1'b1;
      end

      // next chunk: lesser of peer window and bytes left
      if (chunk_req) begin
        left = (rd_off_r < cfg.file_length) ? (cfg.file_length - rd_off_r) : 32'd0;
        len  = (left > {16'd0, peer_win_nxt}) ? peer_win_nxt : left[15:0];
        if (left == 32'd0) begin
          fsm_nxt = rts_pkg::ST_EOF;
          fin_req = !ov_nxt;
        end else if (len != 16'd0) begin
          ov_nxt    = 1'b1;
          os_nxt    = next_seq_nxt;
          ol_nxt    = len;
          ooff_nxt  = rd_off_r;
          otime_nxt = now_r;
          x = rts_pkg::make_res(rts_pkg::FLAG_DAT, next_seq_nxt, 16'd0, len, rd_off_r,
                                1'b0, cfg.advertised_window);
          if (n_v == 2'd0) begin
            r0_v = x;
          end else begin
            r1_v = x;
          end
          n_v          = n_v + 2'd1;
          rd_off_nxt   = rd_off_r + {16'd0, len};
          next_seq_nxt = next_seq_nxt + len;
        end
      end

      if (fin_req) begin
        fsm_nxt     = rts_pkg::ST_FIN;
        exp_ack_nxt = next_seq_nxt;
        x = rts_pkg::make_res(rts_pkg::FLAG_FIN, next_seq_nxt, 16'd0, 16'd0, 32'd0,
                              1'b0, cfg.advertised_window);
        if (n_v == 2'd0) begin
          r0_v = x;
        end else begin
          r1_v = x;
        end
        n_v = n_v + 2'd1;
      end
    end
  end

  // mark the final result of the item
  always_comb begin
    res0  = r0_v;
    res1  = r1_v;
    res_n = n_v;
    if (n_v == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r        <= rts_pkg::ST_WAITING;
      exp_ack_r    <= '0;
      next_seq_r   <= '0;
      last_acked_r <= '0;
      peer_win_r   <= '0;
      rd_off_r     <= '0;
      ov_r         <= 1'b0;
      os_r         <= '0;
      ol_r         <= '0;
      ooff_r       <= '0;
      otime_r      <= '0;
      now_r        <= '0;
    end else begin
      fsm_r        <= fsm_nxt;
      exp_ack_r    <= exp_ack_nxt;
      next_seq_r   <= next_seq_nxt;
      last_acked_r <= last_acked_nxt;
      peer_win_r   <= peer_win_nxt;
      rd_off_r     <= rd_off_nxt;
      ov_r         <= ov_nxt;
      os_r         <= os_nxt;
      ol_r         <= ol_nxt;
      ooff_r       <= ooff_nxt;
      otime_r      <= otime_nxt;
      now_r        <= now_nxt;
    end
  end

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    fsm_r == rts_pkg::ST_DONE |=> fsm_r == rts_pkg::ST_DONE)
    else $error("left closed state");

  a_outstanding_len: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> ol_r != 16'd0)
    else $error("empty chunk outstanding");

  a_two_needs_ack: assert property (@(posedge clk) disable iff (!rst_n)
    res_n == 2'd2 |-> res0.tx_type == rts_pkg::FLAG_ACK)
    else $error("second result without handshake ack");

endmodule

// ===== sv/rts_result_queue.sv =====
// Result queue of the sender: takes up to two headers per cycle and hands
// them out one transfer at a time. Uses rts_pkg for the item type.
module rts_result_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [1:0]                     push_n,
  input  rts_pkg::out_item_t             push0,
  input  rts_pkg::out_item_t             push1,
  input  logic                           pop,
  output rts_pkg::out_item_t             head,
  output logic                           not_empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rts_pkg::out_item_t q_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_p1, wr_p2;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_p1 = wrap_inc(wr_r);
  assign wr_p2 = wrap_inc(wr_p1);

  always_comb begin
    case (push_n)
      2'd1:    wr_nxt = wr_p1;
      2'd2:    wr_nxt = wr_p2;
      default: wr_nxt = wr_r;
    endcase
    rd_nxt    = pop ? wrap_inc(rd_r) : rd_r;
    count_nxt = count_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  assign head      = q_r[rd_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("result queue overflow");

endmodule
